// ===== design/lod_budget_batch_planner_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the detail-level batch planner
// Shorthand for clocked, reset-qualified concurrent checks.
// ----------------------------------------------------------------------------
`ifndef LOD_BUDGET_BATCH_PLANNER_MACROS_SVH
`define LOD_BUDGET_BATCH_PLANNER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LBBP_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define LBBP_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== design/lbbp_pkg.sv =====
// ----------------------------------------------------------------------------
// lbbp_pkg
// Field widths, defaults, codes and shared types of the batch planner.
// ----------------------------------------------------------------------------
package lbbp_pkg;

   localparam int MODE_W      = 3;
   localparam int OBJECT_W    = 4;
   localparam int LEVEL_W     = 2;
   localparam int COUNT_W     = 16;
   localparam int OBJ_COUNT_W = 5;
   localparam int LOD_COUNT_W = 3;
   localparam int CSR_IDX_W   = 2;
   localparam int CSR_DATA_W  = 5;

   localparam int MAX_OBJECTS_DEF  = 16;
   localparam int MAX_LEVELS_DEF   = 4;
   localparam int INDEX_BUDGET_DEF = 32'h10000;

   localparam logic [OBJ_COUNT_W-1:0] OBJECT_COUNT_RST = 5'd16;
   localparam logic [LOD_COUNT_W-1:0] LOD_COUNT_RST    = 3'd4;

   typedef enum logic [MODE_W-1:0] {
      MODE_SET_ENABLED = 3'd0,
      MODE_SET_LEVEL   = 3'd1,
      MODE_SET_VISIBLE = 3'd2,
      MODE_LOAD_COUNTS = 3'd3,
      MODE_REBUILD     = 3'd4
   } mode_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_OBJECT_COUNT = 2'd0,
      CSR_LOD_COUNT    = 2'd1
   } csr_index_type;

   typedef enum logic [2:0] {
      ALU_NONE    = 3'd0,
      ALU_CLEAR   = 3'd1,
      ALU_SUM_ADD = 3'd2,
      ALU_SUM_SUB = 3'd3,
      ALU_VTX_ADD = 3'd4,
      ALU_IDX_ADD = 3'd5
   } alu_op_type;

   typedef struct packed {
      alu_op_type           op;
      logic [COUNT_W-1:0]   operand;
   } alu_cmd_type;

endpackage

// ===== design/lbbp_ram.sv =====
// ----------------------------------------------------------------------------
// lbbp_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module lbbp_ram #(
   parameter  int WIDTH  = 32,
   parameter  int DEPTH  = 64,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== design/lbbp_alu.sv =====
// ----------------------------------------------------------------------------
// lbbp_alu
// Shared adder/subtractor with the index-sum and running-base accumulators.
// ----------------------------------------------------------------------------
module lbbp_alu
   import lbbp_pkg::*;
#(
   parameter int SUM_W = 20
) (
   input  logic               clock,
   input  alu_cmd_type        cmd,
   output logic [SUM_W-1:0]   sum_acc,
   output logic [COUNT_W-1:0] vtx_acc,
   output logic [COUNT_W-1:0] idx_acc
);

   logic [SUM_W-1:0]   sum_ff;
   logic [COUNT_W-1:0] vtx_ff;
   logic [COUNT_W-1:0] idx_ff;
   logic [SUM_W-1:0]   acc_a;
   logic [SUM_W-1:0]   opnd;
   logic               sub;
   logic [SUM_W-1:0]   result;

   // One adder serves every accumulator; the base counters wrap at 16 bits.
   always_comb begin
      acc_a = '0;
      sub   = 1'b0;
      unique case (cmd.op)
         ALU_SUM_ADD: acc_a = sum_ff;
         ALU_SUM_SUB: begin
            acc_a = sum_ff;
            sub   = 1'b1;
         end
         ALU_VTX_ADD: acc_a = SUM_W'(vtx_ff);
         ALU_IDX_ADD: acc_a = SUM_W'(idx_ff);
         default:     acc_a = '0;
      endcase
      opnd   = SUM_W'(cmd.operand);
      result = sub ? (acc_a - opnd) : (acc_a + opnd);
   end

   always_ff @(posedge clock) begin
      unique case (cmd.op)
         ALU_CLEAR: begin
            sum_ff <= '0;
            vtx_ff <= '0;
            idx_ff <= '0;
         end
         ALU_SUM_ADD, ALU_SUM_SUB: sum_ff <= result;
         ALU_VTX_ADD:              vtx_ff <= result[COUNT_W-1:0];
         ALU_IDX_ADD:              idx_ff <= result[COUNT_W-1:0];
         default: begin
         end
      endcase
   end

   assign sum_acc = sum_ff;
   assign vtx_acc = vtx_ff;
   assign idx_acc = idx_ff;

endmodule

// ===== design/lod_budget_batch_planner.sv =====
// ----------------------------------------------------------------------------
// lod_budget_batch_planner
// Detail-level batch planner: object table, budget pass and placement rows.
// ----------------------------------------------------------------------------
// Set and load items are taken in the idle state and return nothing. A
// rebuild item walks the object table three times under a small sequencer,
// all arithmetic going through one shared adder and all count reads through
// the single read port of the count RAM. The summing walk reads and adds the
// index count of each active object, the coarsening walk takes off the count
// of each object moved and adds that of its next coarser level, and the
// emitting walk gives a placement row per active object, adding its vertex
// and then its index count, before the totals row; a stalled result channel
// holds the walk. A clean batch goes straight to the totals row. The block is
// not ready for items or register writes while a rebuild is under way.
// ----------------------------------------------------------------------------
`include "lod_budget_batch_planner_macros.svh"

module lod_budget_batch_planner
   import lbbp_pkg::*;
#(
   parameter int MAX_OBJECTS  = MAX_OBJECTS_DEF,
   parameter int MAX_LEVELS   = MAX_LEVELS_DEF,
   parameter int INDEX_BUDGET = INDEX_BUDGET_DEF
) (
   input  logic                  clock,
   input  logic                  reset,

   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [MODE_W-1:0]     req_mode,
   input  logic [OBJECT_W-1:0]   req_object,
   input  logic [LEVEL_W-1:0]    req_level,
   input  logic                  req_flag,
   input  logic [COUNT_W-1:0]    req_vertex_count,
   input  logic [COUNT_W-1:0]    req_index_count,

   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [OBJECT_W-1:0]   rsp_object_out,
   output logic [LEVEL_W-1:0]    rsp_chosen_level,
   output logic [COUNT_W-1:0]    rsp_vertex_base,
   output logic [COUNT_W-1:0]    rsp_index_base,
   output logic                  rsp_is_total,
   output logic                  rsp_rebuilt,

   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   // Widths that follow from the table sizes.
   localparam int OBJ_W   = (MAX_OBJECTS > 1) ? $clog2(MAX_OBJECTS) : 1;
   localparam int CNT_W   = $clog2(MAX_OBJECTS + 1);
   localparam int LVL_W   = (MAX_LEVELS > 1) ? $clog2(MAX_LEVELS) : 1;
   localparam int NLEV_W  = $clog2(MAX_LEVELS + 1);
   localparam int DEPTH   = MAX_OBJECTS * MAX_LEVELS;
   localparam int ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int DATA_W  = COUNT_W + ((MAX_OBJECTS > 1) ? $clog2(MAX_OBJECTS) : 0);
   localparam int BUD_W   = $clog2(INDEX_BUDGET + 1);
   localparam int SUM_W   = (DATA_W > BUD_W) ? DATA_W : BUD_W;
   localparam int RC_W    = (CNT_W > OBJ_COUNT_W) ? CNT_W : OBJ_COUNT_W;
   localparam int LC_W    = (NLEV_W > LOD_COUNT_W) ? NLEV_W : LOD_COUNT_W;
   localparam int OC_W    = (CNT_W > OBJECT_W) ? CNT_W : OBJECT_W;
   localparam int LE_W    = (NLEV_W > LEVEL_W) ? NLEV_W : LEVEL_W;

   typedef enum logic [9:0] {
      S_IDLE     = 10'b00_0000_0001,
      S_SUM_RD   = 10'b00_0000_0010,
      S_SUM_ACC  = 10'b00_0000_0100,
      S_DOWN_CHK = 10'b00_0000_1000,
      S_DOWN_SUB = 10'b00_0001_0000,
      S_DOWN_ADD = 10'b00_0010_0000,
      S_EMIT_CHK = 10'b00_0100_0000,
      S_EMIT_VTX = 10'b00_1000_0000,
      S_EMIT_IDX = 10'b01_0000_0000,
      S_TOTAL    = 10'b10_0000_0000
   } state_type;

   // Count RAM entry for a level and an object slot.
   function automatic logic [ADDR_W-1:0] slot(input logic [LVL_W-1:0] lvl,
                                             input logic [OBJ_W-1:0] obj);
      slot = ADDR_W'(ADDR_W'(lvl) * ADDR_W'(MAX_OBJECTS)) + ADDR_W'(obj);
   endfunction

   state_type               state_ff, state_in;
   logic [CNT_W-1:0]        j_ff, j_in;
   logic [OBJ_COUNT_W-1:0]  object_count_ff;
   logic [LOD_COUNT_W-1:0]  lod_count_ff;
   logic [MAX_OBJECTS-1:0]  en_ff;
   logic [MAX_OBJECTS-1:0]  vis_ff;
   logic [LVL_W-1:0]        lvl_tab_ff [MAX_OBJECTS];
   logic                    dirty_ff;
   logic [COUNT_W-1:0]      last_vtx_ff;
   logic [COUNT_W-1:0]      last_idx_ff;

   logic                    rsp_valid_ff;
   logic [OBJECT_W-1:0]     rsp_object_ff;
   logic [LEVEL_W-1:0]      rsp_level_ff;
   logic [COUNT_W-1:0]      rsp_vbase_ff;
   logic [COUNT_W-1:0]      rsp_ibase_ff;
   logic                    rsp_total_ff;
   logic                    rsp_rebuilt_ff;

   logic                    req_fire;
   logic                    csr_fire;
   logic                    out_free;
   logic [CNT_W-1:0]        rows;
   logic [NLEV_W-1:0]       nlev;
   logic [OBJ_W-1:0]        cur_obj;
   logic [LVL_W-1:0]        cur_lvl;
   logic [LVL_W-1:0]        lvl_fix;
   logic [LVL_W-1:0]        lvl_up;
   logic [LVL_W-1:0]        set_lvl;
   logic                    cur_active;
   logic                    can_coarsen;
   logic                    over_budget;
   logic                    obj_ok;
   logic                    load_lvl_ok;
   logic                    j_done;

   logic                    en_we, vis_we, lt_we;
   logic [LVL_W-1:0]        lt_wdata;
   logic                    dirty_set, tot_save;
   logic                    row_load, row_total;

   logic                    ram_we, ram_re;
   logic [ADDR_W-1:0]       ram_waddr, ram_raddr;
   logic [2*COUNT_W-1:0]    ram_rdata;
   logic [COUNT_W-1:0]      rd_vertex, rd_index;

   alu_cmd_type             alu_cmd;
   logic [SUM_W-1:0]        sum_acc;
   logic [COUNT_W-1:0]      vtx_acc, idx_acc;

   assign req_ready = (state_ff == S_IDLE);
   assign csr_ready = (state_ff == S_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign csr_fire  = csr_valid && csr_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;

   // Registers as the walks see them: object count saturates to the table
   // size, and a level count of zero behaves as a single level.
   always_comb begin
      if (RC_W'(object_count_ff) > RC_W'(MAX_OBJECTS)) begin
         rows = CNT_W'(MAX_OBJECTS);
      end else begin
         rows = CNT_W'(object_count_ff);
      end
      if (lod_count_ff == '0) begin
         nlev = NLEV_W'(1);
      end else if (LC_W'(lod_count_ff) > LC_W'(MAX_LEVELS)) begin
         nlev = NLEV_W'(MAX_LEVELS);
      end else begin
         nlev = NLEV_W'(lod_count_ff);
      end
   end

   // The object table has one read point: the addressed slot while idle,
   // the walk position otherwise.
   assign cur_obj     = (state_ff == S_IDLE) ? OBJ_W'(req_object) : j_ff[OBJ_W-1:0];
   assign cur_lvl     = lvl_tab_ff[cur_obj];
   assign cur_active  = en_ff[cur_obj] && vis_ff[cur_obj];
   assign lvl_fix     = (NLEV_W'(cur_lvl) >= nlev) ? '0 : cur_lvl;
   assign lvl_up      = cur_lvl + LVL_W'(1);
   assign can_coarsen = (NLEV_W'(cur_lvl) + NLEV_W'(1)) < nlev;
   assign over_budget = sum_acc >= SUM_W'(INDEX_BUDGET);
   assign j_done      = j_ff >= rows;

   assign obj_ok      = OC_W'(req_object) < OC_W'(MAX_OBJECTS);
   assign load_lvl_ok = LE_W'(req_level) < LE_W'(MAX_LEVELS);
   assign set_lvl     = (LE_W'(req_level) < LE_W'(nlev)) ? LVL_W'(req_level) : '0;

   assign ram_we    = req_fire && (req_mode == MODE_LOAD_COUNTS) && obj_ok && load_lvl_ok;
   assign ram_waddr = slot(LVL_W'(req_level), cur_obj);
   assign rd_vertex = ram_rdata[2*COUNT_W-1:COUNT_W];
   assign rd_index  = ram_rdata[COUNT_W-1:0];

   // Sequencer. A dirty rebuild first corrects stale levels while summing the
   // active index counts, then coarsens objects in slot order while the sum
   // is over budget, then emits placement rows and finally the totals row.
   always_comb begin
      state_in        = state_ff;
      j_in            = j_ff;
      alu_cmd.op      = ALU_NONE;
      alu_cmd.operand = rd_index;
      ram_re          = 1'b0;
      ram_raddr       = slot(cur_lvl, cur_obj);
      en_we           = 1'b0;
      vis_we          = 1'b0;
      lt_we           = 1'b0;
      lt_wdata        = cur_lvl;
      dirty_set       = 1'b0;
      tot_save        = 1'b0;
      row_load        = 1'b0;
      row_total       = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               unique case (req_mode)
                  MODE_SET_ENABLED: begin
                     if (obj_ok && (en_ff[cur_obj] != req_flag)) begin
                        en_we     = 1'b1;
                        dirty_set = vis_ff[cur_obj];
                     end
                  end
                  MODE_SET_LEVEL: begin
                     if (obj_ok && (cur_lvl != set_lvl)) begin
                        lt_we     = 1'b1;
                        lt_wdata  = set_lvl;
                        dirty_set = en_ff[cur_obj];
                     end
                  end
                  MODE_SET_VISIBLE: begin
                     if (obj_ok && (vis_ff[cur_obj] != req_flag)) begin
                        vis_we    = 1'b1;
                        dirty_set = en_ff[cur_obj];
                     end
                  end
                  MODE_REBUILD: begin
                     alu_cmd.op = ALU_CLEAR;
                     j_in       = '0;
                     state_in   = dirty_ff ? S_SUM_RD : S_TOTAL;
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_SUM_RD: begin
            if (j_done) begin
               j_in     = '0;
               state_in = S_DOWN_CHK;
            end else begin
               lt_we    = 1'b1;
               lt_wdata = lvl_fix;
               if (cur_active) begin
                  ram_re    = 1'b1;
                  ram_raddr = slot(lvl_fix, cur_obj);
                  state_in  = S_SUM_ACC;
               end else begin
                  j_in = j_ff + CNT_W'(1);
               end
            end
         end
         S_SUM_ACC: begin
            alu_cmd.op = ALU_SUM_ADD;
            j_in       = j_ff + CNT_W'(1);
            state_in   = S_SUM_RD;
         end
         S_DOWN_CHK: begin
            if (!over_budget || j_done) begin
               j_in     = '0;
               state_in = S_EMIT_CHK;
            end else if (cur_active && can_coarsen) begin
               ram_re   = 1'b1;
               state_in = S_DOWN_SUB;
            end else begin
               j_in = j_ff + CNT_W'(1);
            end
         end
         S_DOWN_SUB: begin
            alu_cmd.op = ALU_SUM_SUB;
            ram_re     = 1'b1;
            ram_raddr  = slot(lvl_up, cur_obj);
            state_in   = S_DOWN_ADD;
         end
         S_DOWN_ADD: begin
            alu_cmd.op = ALU_SUM_ADD;
            lt_we      = 1'b1;
            lt_wdata   = lvl_up;
            j_in       = j_ff + CNT_W'(1);
            state_in   = S_DOWN_CHK;
         end
         S_EMIT_CHK: begin
            if (j_done) begin
               state_in = S_TOTAL;
            end else if (cur_active) begin
               ram_re   = 1'b1;
               state_in = S_EMIT_VTX;
            end else begin
               j_in = j_ff + CNT_W'(1);
            end
         end
         S_EMIT_VTX: begin
            // The row takes the bases as they stand before this object.
            if (out_free) begin
               row_load        = 1'b1;
               alu_cmd.op      = ALU_VTX_ADD;
               alu_cmd.operand = rd_vertex;
               state_in        = S_EMIT_IDX;
            end
         end
         S_EMIT_IDX: begin
            alu_cmd.op = ALU_IDX_ADD;
            j_in       = j_ff + CNT_W'(1);
            state_in   = S_EMIT_CHK;
         end
         S_TOTAL: begin
            if (out_free) begin
               row_load  = 1'b1;
               row_total = 1'b1;
               tot_save  = dirty_ff;
               state_in  = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= S_IDLE;
         j_ff            <= '0;
         object_count_ff <= OBJECT_COUNT_RST;
         lod_count_ff    <= LOD_COUNT_RST;
         en_ff           <= '1;
         vis_ff          <= '1;
         dirty_ff        <= 1'b1;
         last_vtx_ff     <= '0;
         last_idx_ff     <= '0;
         for (int i = 0; i < MAX_OBJECTS; i++) begin
            lvl_tab_ff[i] <= '0;
         end
      end else begin
         state_ff <= state_in;
         j_ff     <= j_in;
         if (csr_fire) begin
            unique case (csr_index)
               CSR_OBJECT_COUNT: object_count_ff <= csr_data[OBJ_COUNT_W-1:0];
               CSR_LOD_COUNT:    lod_count_ff    <= csr_data[LOD_COUNT_W-1:0];
               default: begin
               end
            endcase
         end
         if (en_we) begin
            en_ff[cur_obj] <= req_flag;
         end
         if (vis_we) begin
            vis_ff[cur_obj] <= req_flag;
         end
         if (lt_we) begin
            lvl_tab_ff[cur_obj] <= lt_wdata;
         end
         if (dirty_set) begin
            dirty_ff <= 1'b1;
         end else if (tot_save) begin
            dirty_ff <= 1'b0;
         end
         if (tot_save) begin
            last_vtx_ff <= vtx_acc;
            last_idx_ff <= idx_acc;
         end
      end
   end

   // Result register: a row waits here while the sequencer moves on.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (row_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (row_load) begin
         rsp_object_ff  <= row_total ? '0 : OBJECT_W'(j_ff);
         rsp_level_ff   <= row_total ? '0 : LEVEL_W'(cur_lvl);
         rsp_vbase_ff   <= (row_total && !dirty_ff) ? last_vtx_ff : vtx_acc;
         rsp_ibase_ff   <= (row_total && !dirty_ff) ? last_idx_ff : idx_acc;
         rsp_total_ff   <= row_total;
         rsp_rebuilt_ff <= row_total ? dirty_ff : 1'b1;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_object_out   = rsp_object_ff;
   assign rsp_chosen_level = rsp_level_ff;
   assign rsp_vertex_base  = rsp_vbase_ff;
   assign rsp_index_base   = rsp_ibase_ff;
   assign rsp_is_total     = rsp_total_ff;
   assign rsp_rebuilt      = rsp_rebuilt_ff;

   // Vertex and index counts share one RAM word per level and slot.
   lbbp_ram #(
      .WIDTH (2 * COUNT_W),
      .DEPTH (DEPTH)
   ) u_count_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data ({req_vertex_count, req_index_count}),
      .rd_en   (ram_re),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   lbbp_alu #(
      .SUM_W (SUM_W)
   ) u_alu (
      .clock   (clock),
      .cmd     (alu_cmd),
      .sum_acc (sum_acc),
      .vtx_acc (vtx_acc),
      .idx_acc (idx_acc)
   );

   // Only an accepted rebuild item may start the walks.
   `LBBP_ASSERT_NEXT(a_idle_holds, clock, reset,
      state_ff == S_IDLE && !(req_fire && req_mode == MODE_REBUILD),
      state_ff == S_IDLE, "planner left idle without a rebuild item")
   // The dirty mark is cleared by the totals row of a rebuild and nothing else.
   `LBBP_ASSERT_NEXT(a_dirty_holds, clock, reset,
      dirty_ff && state_ff != S_TOTAL,
      dirty_ff, "dirty mark lost outside the totals row")
   // A walk never runs past the objects in use.
   `LBBP_ASSERT_NOW(a_walk_bound, clock, reset,
      state_ff != S_IDLE,
      j_ff <= rows, "object walk ran past the objects in use")
   // The totals of a real rebuild are kept for the next clean rebuild.
   `LBBP_ASSERT_NEXT(a_totals_kept, clock, reset,
      state_ff == S_TOTAL && out_free && dirty_ff,
      !dirty_ff && last_vtx_ff == $past(vtx_acc) && last_idx_ff == $past(idx_acc),
      "rebuild totals not kept")

endmodule

// ===== tb/lbbp_checker.sv =====
// ----------------------------------------------------------------------------
// lbbp_checker
// Watches the item, result and register channels of the batch planner, keeps
// its own copy of the object table and settings, predicts every placement
// and totals row and compares the rows that come out against it.
// ----------------------------------------------------------------------------
module lbbp_checker
   import lbbp_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,

   input  logic                  req_valid,
   input  logic                  req_ready,
   input  logic [MODE_W-1:0]     req_mode,
   input  logic [OBJECT_W-1:0]   req_object,
   input  logic [LEVEL_W-1:0]    req_level,
   input  logic                  req_flag,
   input  logic [COUNT_W-1:0]    req_vertex_count,
   input  logic [COUNT_W-1:0]    req_index_count,

   input  logic                  rsp_valid,
   input  logic                  rsp_ready,
   input  logic [OBJECT_W-1:0]   rsp_object_out,
   input  logic [LEVEL_W-1:0]    rsp_chosen_level,
   input  logic [COUNT_W-1:0]    rsp_vertex_base,
   input  logic [COUNT_W-1:0]    rsp_index_base,
   input  logic                  rsp_is_total,
   input  logic                  rsp_rebuilt,

   input  logic                  csr_valid,
   input  logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data,

   output int                    rows_pending,
   output int                    mismatch_count
);

   localparam int COUNT_DEPTH = MAX_OBJECTS_DEF * MAX_LEVELS_DEF;

   typedef struct packed {
      logic [OBJECT_W-1:0] slot_id;
      logic [LEVEL_W-1:0]  level;
      logic [COUNT_W-1:0]  vertex_base;
      logic [COUNT_W-1:0]  index_base;
      logic                is_total;
      logic                rebuilt;
   } placement_row_type;

   placement_row_type expected_rows[$];

   logic                   enabled_bit [MAX_OBJECTS_DEF];
   logic                   visible_bit [MAX_OBJECTS_DEF];
   logic [LEVEL_W-1:0]     level_of    [MAX_OBJECTS_DEF];
   logic [COUNT_W-1:0]     vertices_at [COUNT_DEPTH];
   logic [COUNT_W-1:0]     indices_at  [COUNT_DEPTH];
   logic                   batch_dirty;
   logic [COUNT_W-1:0]     kept_vertex_total;
   logic [COUNT_W-1:0]     kept_index_total;
   logic [OBJ_COUNT_W-1:0] cfg_objects;
   logic [LOD_COUNT_W-1:0] cfg_levels;
   int                     errors = 0;

   function automatic int objects_in_use();
      return (int'(cfg_objects) > MAX_OBJECTS_DEF) ? MAX_OBJECTS_DEF : int'(cfg_objects);
   endfunction

   function automatic int levels_in_use();
      int n;
      n = int'(cfg_levels);
      if (n == 0) n = 1;
      return (n > MAX_LEVELS_DEF) ? MAX_LEVELS_DEF : n;
   endfunction

   function automatic bit is_active(int j);
      return enabled_bit[j] && visible_bit[j];
   endfunction

   // Count entries are laid out level-major.
   function automatic int entry_of(int lvl, int j);
      return lvl * MAX_OBJECTS_DEF + j;
   endfunction

   function automatic void push_row(int obj, int lvl, int unsigned vb, int unsigned ib,
                                    logic total, logic ran);
      placement_row_type row;
      row.slot_id     = OBJECT_W'(obj);
      row.level       = LEVEL_W'(lvl);
      row.vertex_base = COUNT_W'(vb);
      row.index_base  = COUNT_W'(ib);
      row.is_total    = total;
      row.rebuilt     = ran;
      expected_rows.push_back(row);
   endfunction

   task automatic plan_rebuild();
      int          rows;
      int          nlev;
      int          lvl;
      int unsigned budget_sum;
      int unsigned vtx;
      int unsigned idx;
      rows       = objects_in_use();
      nlev       = levels_in_use();
      budget_sum = 0;
      vtx        = 0;
      idx        = 0;
      if (!batch_dirty) begin
         push_row(0, 0, 32'(kept_vertex_total), 32'(kept_index_total), 1'b1, 1'b0);
         return;
      end
      // Levels left over from a larger detail setting fall back to the finest.
      for (int j = 0; j < rows; j++) begin
         if (int'(level_of[j]) >= nlev) level_of[j] = '0;
      end
      for (int j = 0; j < rows; j++) begin
         if (is_active(j)) budget_sum += indices_at[entry_of(int'(level_of[j]), j)];
      end
      // One ordered coarsening pass, stopping as soon as the budget is met.
      for (int j = 0; budget_sum >= INDEX_BUDGET_DEF && j < rows; j++) begin
         lvl = int'(level_of[j]);
         if (is_active(j) && lvl + 1 < nlev) begin
            budget_sum -= indices_at[entry_of(lvl, j)];
            level_of[j] = LEVEL_W'(lvl + 1);
            budget_sum += indices_at[entry_of(lvl + 1, j)];
         end
      end
      for (int j = 0; j < rows; j++) begin
         if (is_active(j)) begin
            lvl = int'(level_of[j]);
            push_row(j, lvl, vtx, idx, 1'b0, 1'b1);
            vtx = (vtx + vertices_at[entry_of(lvl, j)]) & 32'hFFFF;
            idx = (idx + indices_at[entry_of(lvl, j)]) & 32'hFFFF;
         end
      end
      kept_vertex_total = COUNT_W'(vtx);
      kept_index_total  = COUNT_W'(idx);
      push_row(0, 0, vtx, idx, 1'b1, 1'b1);
      batch_dirty = 1'b0;
   endtask

   task automatic take_item();
      int                 obj;
      logic [LEVEL_W-1:0] new_level;
      obj       = int'(req_object);
      new_level = (int'(req_level) < levels_in_use()) ? req_level : '0;
      case (req_mode)
         MODE_REBUILD: plan_rebuild();
         MODE_SET_ENABLED: begin
            if (enabled_bit[obj] != req_flag) begin
               enabled_bit[obj] = req_flag;
               if (visible_bit[obj]) batch_dirty = 1'b1;
            end
         end
         MODE_SET_LEVEL: begin
            if (level_of[obj] != new_level) begin
               level_of[obj] = new_level;
               if (enabled_bit[obj]) batch_dirty = 1'b1;
            end
         end
         MODE_SET_VISIBLE: begin
            if (visible_bit[obj] != req_flag) begin
               visible_bit[obj] = req_flag;
               if (enabled_bit[obj]) batch_dirty = 1'b1;
            end
         end
         MODE_LOAD_COUNTS: begin
            vertices_at[entry_of(int'(req_level), obj)] = req_vertex_count;
            indices_at[entry_of(int'(req_level), obj)]  = req_index_count;
         end
         default: ;
      endcase
   endtask

   task automatic check_field(string name, logic [COUNT_W-1:0] want, logic [COUNT_W-1:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         errors++;
      end
   endtask

   always @(posedge clock) begin
      placement_row_type row;
      if (reset) begin
         for (int j = 0; j < MAX_OBJECTS_DEF; j++) begin
            enabled_bit[j] = 1'b1;
            visible_bit[j] = 1'b1;
            level_of[j]    = '0;
         end
         batch_dirty       = 1'b1;
         kept_vertex_total = '0;
         kept_index_total  = '0;
         cfg_objects       = OBJECT_COUNT_RST;
         cfg_levels        = LOD_COUNT_RST;
         expected_rows.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_OBJECT_COUNT: cfg_objects = csr_data[OBJ_COUNT_W-1:0];
               CSR_LOD_COUNT:    cfg_levels  = csr_data[LOD_COUNT_W-1:0];
               default: ;
            endcase
         end
         if (req_valid && req_ready) take_item();
         if (rsp_valid && rsp_ready) begin
            if (expected_rows.size() == 0) begin
               $error("unexpected row: object_out %0d, is_total %0d", rsp_object_out,
                      rsp_is_total);
               errors++;
            end else begin
               row = expected_rows.pop_front();
               check_field("object_out", COUNT_W'(row.slot_id), COUNT_W'(rsp_object_out));
               check_field("chosen_level", COUNT_W'(row.level), COUNT_W'(rsp_chosen_level));
               check_field("vertex_base", row.vertex_base, rsp_vertex_base);
               check_field("index_base", row.index_base, rsp_index_base);
               check_field("is_total", COUNT_W'(row.is_total), COUNT_W'(rsp_is_total));
               check_field("rebuilt", COUNT_W'(row.rebuilt), COUNT_W'(rsp_rebuilt));
            end
         end
      end
      rows_pending   <= expected_rows.size();
      mismatch_count <= errors;
   end

endmodule

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for the detail-level batch planner. The count table is
// filled first, then a directed part covers the dirty-marking rules, clean
// rebuilds, level correction and register extremes, and random phases follow
// under changing settings and random idling on both channels. All prediction
// and comparison is done by the checker instantiated beside the block.
// ----------------------------------------------------------------------------
module tb
   import lbbp_pkg::*;
();

   // Register indexes that map to no register; writes to them must be harmless.
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_LO = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_HI = 2'd3;
   // Item codes above the rebuild code, which the block must ignore.
   localparam logic [MODE_W-1:0]    MODE_SPARE_FIRST = 3'd5;
   localparam logic [MODE_W-1:0]    MODE_SPARE_LAST  = 3'd7;

   localparam int CYCLE_LIMIT     = 1_000_000;
   localparam int SETTLE_CYCLES   = 8;
   localparam int RANDOM_PHASES   = 8;
   localparam int ITEMS_PER_PHASE = 12;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;

   logic                  req_valid        = 1'b0;
   logic                  req_ready;
   logic [MODE_W-1:0]     req_mode         = '0;
   logic [OBJECT_W-1:0]   req_object       = '0;
   logic [LEVEL_W-1:0]    req_level        = '0;
   logic                  req_flag         = 1'b0;
   logic [COUNT_W-1:0]    req_vertex_count = '0;
   logic [COUNT_W-1:0]    req_index_count  = '0;

   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   logic [OBJECT_W-1:0]   rsp_object_out;
   logic [LEVEL_W-1:0]    rsp_chosen_level;
   logic [COUNT_W-1:0]    rsp_vertex_base;
   logic [COUNT_W-1:0]    rsp_index_base;
   logic                  rsp_is_total;
   logic                  rsp_rebuilt;

   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_data  = '0;

   int                    rows_pending;
   int                    mismatch_count;
   int                    cycle_count = 0;
   int                    rsp_hold    = 0;
   bit                    req_gaps_on = 1'b1;
   bit                    rsp_gaps_on = 1'b1;

   lod_budget_batch_planner DUT (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_mode         (req_mode),
      .req_object       (req_object),
      .req_level        (req_level),
      .req_flag         (req_flag),
      .req_vertex_count (req_vertex_count),
      .req_index_count  (req_index_count),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_object_out   (rsp_object_out),
      .rsp_chosen_level (rsp_chosen_level),
      .rsp_vertex_base  (rsp_vertex_base),
      .rsp_index_base   (rsp_index_base),
      .rsp_is_total     (rsp_is_total),
      .rsp_rebuilt      (rsp_rebuilt),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_data         (csr_data)
   );

   lbbp_checker row_checker (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_mode         (req_mode),
      .req_object       (req_object),
      .req_level        (req_level),
      .req_flag         (req_flag),
      .req_vertex_count (req_vertex_count),
      .req_index_count  (req_index_count),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_object_out   (rsp_object_out),
      .rsp_chosen_level (rsp_chosen_level),
      .rsp_vertex_base  (rsp_vertex_base),
      .rsp_index_base   (rsp_index_base),
      .rsp_is_total     (rsp_is_total),
      .rsp_rebuilt      (rsp_rebuilt),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_data         (csr_data),
      .rows_pending     (rows_pending),
      .mismatch_count   (mismatch_count)
   );

   always #5 clock = ~clock;

   // The run is cut short if it ever hangs; the limit is far beyond a
   // correct run even with every item a full rebuild under long stalls.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   // Mostly no gap, often a short one, now and then a long one.
   function automatic int gap_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   // Index counts shrink at coarser levels, so that the budget pass usually
   // has somewhere to go, with the extremes thrown in on purpose.
   function automatic logic [COUNT_W-1:0] index_count_for(int lvl);
      case ($urandom_range(0, 7))
         0:       return '1;
         1:       return '0;
         default: return COUNT_W'($urandom_range(0, 32'hFFFF >> (2 * lvl)));
      endcase
   endfunction

   // The result side stalls in bursts; a stretch with stalling switched off
   // keeps ready high throughout.
   always @(posedge clock) begin
      if (rsp_hold > 0) begin
         rsp_ready <= 1'b0;
         rsp_hold  <= rsp_hold - 1;
      end else begin
         rsp_ready <= 1'b1;
         if (rsp_gaps_on && $urandom_range(0, 3) == 0) rsp_hold <= gap_len();
      end
   end

   // Presents one item and returns at the edge where it is accepted. When no
   // gap follows the previous item, valid simply stays high for this one.
   task automatic send_item(logic [MODE_W-1:0] mode, int obj, int lvl, logic flag,
                            logic [COUNT_W-1:0] vcount, logic [COUNT_W-1:0] icount);
      int gap;
      gap = req_gaps_on ? gap_len() : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_mode         <= mode;
      req_object       <= OBJECT_W'(obj);
      req_level        <= LEVEL_W'(lvl);
      req_flag         <= flag;
      req_vertex_count <= vcount;
      req_index_count  <= icount;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic send_simple(logic [MODE_W-1:0] mode, int obj, int lvl, logic flag);
      send_item(mode, obj, lvl, flag, COUNT_W'($urandom()), COUNT_W'($urandom()));
   endtask

   // Waits until every predicted row has come out, then lets the block finish
   // any set item still in flight before the caller touches the registers.
   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (rows_pending != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, int value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= CSR_DATA_W'(value);
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   // One random item; set items lean towards raising flags, so that a fair
   // share of the table stays active from phase to phase.
   task automatic random_set_item();
      int   r;
      logic flag;
      r    = $urandom_range(0, 99);
      flag = ($urandom_range(0, 99) < 65);
      if (r < 27)      send_simple(MODE_SET_ENABLED, $urandom_range(0, 15), 0, flag);
      else if (r < 54) send_simple(MODE_SET_VISIBLE, $urandom_range(0, 15), 0, flag);
      else if (r < 80) send_simple(MODE_SET_LEVEL, $urandom_range(0, 15),
                                   $urandom_range(0, 3), 1'($urandom_range(0, 1)));
      else begin
         r = $urandom_range(0, 3);
         send_item(MODE_LOAD_COUNTS, $urandom_range(0, 15), r, 1'($urandom_range(0, 1)),
                   COUNT_W'($urandom()), index_count_for(r));
      end
   endtask

   initial begin
      int sent;
      int burst;
      int r;

      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // The reset values are written back once, so that both registers see a
      // write before anything else happens.
      write_reg(CSR_OBJECT_COUNT, int'(OBJECT_COUNT_RST));
      write_reg(CSR_LOD_COUNT, int'(LOD_COUNT_RST));

      // Every count entry is loaded before the first rebuild, since the batch
      // comes out of reset dirty and a rebuild reads whatever it finds.
      for (int obj = 0; obj < MAX_OBJECTS_DEF; obj++) begin
         for (int lvl = 0; lvl < MAX_LEVELS_DEF; lvl++) begin
            send_item(MODE_LOAD_COUNTS, obj, lvl, 1'($urandom_range(0, 1)),
                      COUNT_W'($urandom()), index_count_for(lvl));
         end
      end

      // Directed part. The first rebuild runs on the reset dirty flag, the
      // second finds the batch clean and only repeats the kept totals.
      send_simple(MODE_REBUILD, 0, 0, 1'b0);
      send_simple(MODE_REBUILD, 15, 3, 1'b1);
      // Disabling a visible object dirties the batch; repeating it does not.
      send_simple(MODE_SET_ENABLED, 3, 0, 1'b0);
      send_simple(MODE_SET_ENABLED, 3, 0, 1'b0);
      send_simple(MODE_SET_VISIBLE, 5, 0, 1'b0);
      send_simple(MODE_SET_LEVEL, 7, 3, 1'b0);
      send_simple(MODE_SET_LEVEL, 4, 3, 1'b0);
      send_simple(MODE_SET_LEVEL, 15, 2, 1'b0);
      // Count extremes: a full object and an empty one.
      send_item(MODE_LOAD_COUNTS, 0, 0, 1'b1, '1, '1);
      send_item(MODE_LOAD_COUNTS, 15, 3, 1'b0, '0, '0);
      send_simple(MODE_REBUILD, 0, 0, 1'b0);
      // Changes to an object that is disabled or hidden leave the batch clean.
      send_simple(MODE_SET_VISIBLE, 3, 0, 1'b0);
      send_simple(MODE_SET_ENABLED, 3, 0, 1'b1);
      send_simple(MODE_SPARE_FIRST, 2, 1, 1'b1);
      send_simple(MODE_SPARE_LAST, 9, 2, 1'b0);
      send_simple(MODE_REBUILD, 0, 0, 1'b0);
      send_simple(MODE_SET_VISIBLE, 3, 0, 1'b1);
      send_simple(MODE_SET_VISIBLE, 5, 0, 1'b1);
      send_simple(MODE_REBUILD, 0, 0, 1'b0);
      settle();

      // Fewer levels than some objects hold: the rebuild folds them back to
      // level zero, and a set level beyond the range is stored as zero.
      write_reg(CSR_LOD_COUNT, 2);
      write_reg(CSR_OBJECT_COUNT, 5);
      write_reg(CSR_SPARE_LO, 31);
      send_simple(MODE_SET_LEVEL, 1, 1, 1'b0);
      send_simple(MODE_SET_LEVEL, 2, 3, 1'b0);
      send_simple(MODE_REBUILD, 0, 0, 1'b0);
      settle();

      // No objects in use: a dirty rebuild gives the totals row alone.
      write_reg(CSR_OBJECT_COUNT, 0);
      write_reg(CSR_LOD_COUNT, 0);
      send_simple(MODE_SET_ENABLED, 0, 0, 1'b0);
      send_simple(MODE_REBUILD, 0, 0, 1'b0);
      settle();

      // Register values beyond the table saturate; the level field keeps only
      // its low bits.
      write_reg(CSR_OBJECT_COUNT, 31);
      write_reg(CSR_LOD_COUNT, 31);
      write_reg(CSR_SPARE_HI, 0);
      send_simple(MODE_SET_ENABLED, 0, 0, 1'b1);
      send_simple(MODE_REBUILD, 0, 0, 1'b0);
      settle();

      // Random phases. Each phase picks new settings and decides whether either
      // side idles. Most of the work is short runs of set items closed by a
      // rebuild; the rest is stray rebuilds and ignored codes.
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         r = $urandom_range(0, 9);
         if (r == 0)      write_reg(CSR_OBJECT_COUNT, 0);
         else if (r == 1) write_reg(CSR_OBJECT_COUNT, 1);
         else if (r == 2) write_reg(CSR_OBJECT_COUNT, $urandom_range(17, 31));
         else             write_reg(CSR_OBJECT_COUNT, $urandom_range(2, 16));
         write_reg(CSR_LOD_COUNT, $urandom_range(0, 31));
         if ($urandom_range(0, 3) == 0) begin
            write_reg($urandom_range(0, 1) ? CSR_SPARE_LO : CSR_SPARE_HI,
                      $urandom_range(0, 31));
         end
         req_gaps_on <= ($urandom_range(0, 3) != 0);
         rsp_gaps_on <= ($urandom_range(0, 3) != 0);

         sent = 0;
         while (sent < ITEMS_PER_PHASE) begin
            r = $urandom_range(0, 99);
            if (r < 8) begin
               send_simple(MODE_W'(MODE_SPARE_FIRST + $urandom_range(0, 2)),
                           $urandom_range(0, 15), $urandom_range(0, 3),
                           1'($urandom_range(0, 1)));
            end else if (r < 16) begin
               send_simple(MODE_REBUILD, $urandom_range(0, 15), $urandom_range(0, 3),
                           1'($urandom_range(0, 1)));
               sent++;
            end else begin
               burst = $urandom_range(1, 5);
               repeat (burst) random_set_item();
               sent += burst;
               if ($urandom_range(0, 99) < 80) begin
                  send_simple(MODE_REBUILD, $urandom_range(0, 15), $urandom_range(0, 3),
                              1'($urandom_range(0, 1)));
                  sent++;
               end
            end
         end
         settle();
      end

      if (mismatch_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

// ===== files.f =====
+incdir+design
design/lbbp_pkg.sv
design/lbbp_ram.sv
design/lbbp_alu.sv
design/lod_budget_batch_planner.sv
tb/lbbp_checker.sv
tb/tb.sv
